[src/sblc_pkg.sv]
// ----------------------------------------------------------------------------
// sblc_pkg
// Shared types and constants of the size-budget LRU cache directory.
// ----------------------------------------------------------------------------
package sblc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int SIZE_W  = 32;
    localparam int STAMP_W = 64;
    localparam int TOTAL_W = 36;
    localparam int LIM_W   = 5;
    localparam int CIDX_W  = 4;
    localparam int DATA_W  = SIZE_W + STAMP_W;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [IDX_W-1:0]   age_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [TOTAL_W-1:0] total_t;

    typedef enum logic [1:0] {
        ST_HIT    = 2'd0,
        ST_LOADED = 2'd1,
        ST_STALE  = 2'd2,
        ST_UNREAD = 2'd3
    } status_t;

    localparam logic [CIDX_W-1:0] REG_MAX_BYTES   = 4'd0;
    localparam logic [CIDX_W-1:0] REG_MAX_ENTRIES = 4'd1;

    // Result of one parallel pass over the directory.
    typedef struct packed {
        logic hit;
        idx_t hit_idx;
        logic free;
        idx_t free_idx;
        idx_t old_idx;
    } search_t;

endpackage

[src/sblc_search.sv]
// ----------------------------------------------------------------------------
// sblc_search
// Key match, first free slot and least-recent entry over the directory.
// ----------------------------------------------------------------------------
module sblc_search import sblc_pkg::*; (
    input  key_t [ENTRIES-1:0] keys,
    input  logic [ENTRIES-1:0] valid,
    input  age_t [ENTRIES-1:0] ages,
    input  key_t               key,
    input  cnt_t               count,
    output search_t            res
);

    cnt_t last_rank;

    always_comb begin
        last_rank = cnt_t'(count - cnt_t'(1));
        res = '0;
        // Walking down leaves the lowest matching index in place.
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (valid[i] && keys[i] == key) begin
                res.hit     = 1'b1;
                res.hit_idx = idx_t'(i);
            end
            if (!valid[i]) begin
                res.free     = 1'b1;
                res.free_idx = idx_t'(i);
            end
            // Valid ranks are distinct 0..count-1, so the oldest holds count-1.
            if (valid[i] && cnt_t'(ages[i]) == last_rank) begin
                res.old_idx = idx_t'(i);
            end
        end
    end

endmodule

[src/size_budget_lru_cache.sv]
// ----------------------------------------------------------------------------
// size_budget_lru_cache
// LRU cache directory with a byte budget and an entry limit.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Words
//  s_        in         s_valid / s_ready     request: key, size, stamp, readable
//  m_        out        m_valid / m_ready     result: status, counts, byte total
//  cfg_      in         cfg_valid / cfg_ready register index and write data
//
//  A hit or unreadable item passes look and check; a miss adds insert and trim,
//  and each evicted entry adds read and evict: it reads the victim's size from
//  the entry memory, subtracts it and checks the limits again. One request is
//  worked at a time. A finished result waits in the output register while the
//  next request is taken. Reset is synchronous and empties the directory.
// ----------------------------------------------------------------------------
module size_budget_lru_cache import sblc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KEY_W-1:0]    s_key,
    input  logic [SIZE_W-1:0]   s_item_bytes,
    input  logic [STAMP_W-1:0]  s_stamp,
    input  logic                s_readable,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic                m_stays_cached,
    output logic [4:0]          m_evicted_count,
    output logic [TOTAL_W-1:0]  m_total_bytes,
    output logic [4:0]          m_entry_count,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [TOTAL_W-1:0]  cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOOK  = 8'b0000_0010,
        S_CHECK = 8'b0000_0100,
        S_INS   = 8'b0000_1000,
        S_EVRD  = 8'b0001_0000,
        S_EVICT = 8'b0010_0000,
        S_TRIM  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    key_t [ENTRIES-1:0] key_reg, key_next;
    age_t [ENTRIES-1:0] age_reg, age_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    cnt_t   count_reg, count_next;
    total_t total_reg, total_next;
    total_t max_bytes_reg, max_bytes_next;
    logic [LIM_W-1:0] max_entries_reg, max_entries_next;

    key_t               req_key_reg;
    logic [SIZE_W-1:0]  req_bytes_reg;
    logic [STAMP_W-1:0] req_stamp_reg;
    logic               req_readable_reg;

    logic    hit_reg, hit_next;
    idx_t    hit_idx_reg, hit_idx_next;
    idx_t    slot_reg, slot_next;
    idx_t    victim_reg, victim_next;
    logic    ins_pend_reg, ins_pend_next;
    cnt_t    evicted_reg, evicted_next;
    status_t status_reg, status_next;
    logic    stays_reg, stays_next;

    logic         out_valid_reg, out_valid_next;
    status_t      out_status_reg;
    logic         out_stays_reg;
    cnt_t         out_evicted_reg;
    total_t       out_total_reg;
    cnt_t         out_count_reg;
    logic         out_load;

    // Entry memory: item size and stamp, one word per slot.
    logic [DATA_W-1:0] data_mem [ENTRIES];
    logic [DATA_W-1:0] mem_rdata;
    logic              mem_we;
    idx_t              mem_raddr;
    logic [SIZE_W-1:0]  rd_bytes;
    logic [STAMP_W-1:0] rd_stamp;

    search_t srch;
    cnt_t    limit;
    logic    hit_ok;
    logic    accept;

    sblc_search u_search (
        .keys  (key_reg),
        .valid (valid_reg),
        .ages  (age_reg),
        .key   (req_key_reg),
        .count (count_reg),
        .res   (srch)
    );

    function automatic total_t sub_sat(total_t a, logic [SIZE_W-1:0] b);
        total_t bw;
        bw = total_t'(b);
        return (a >= bw) ? total_t'(a - bw) : '0;
    endfunction

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign rd_bytes  = mem_rdata[DATA_W-1 -: SIZE_W];
    assign rd_stamp  = mem_rdata[STAMP_W-1:0];
    assign limit     = (cnt_t'(max_entries_reg) > cnt_t'(ENTRIES)) ? cnt_t'(ENTRIES)
                                                                   : cnt_t'(max_entries_reg);
    assign hit_ok    = hit_reg && req_readable_reg && rd_bytes == req_bytes_reg
                       && rd_stamp == req_stamp_reg;
    assign mem_we    = (state_reg == S_INS) && (count_reg != cnt_t'(ENTRIES));
    assign mem_raddr = (state_reg == S_EVRD) ? srch.old_idx : srch.hit_idx;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            data_mem[srch.free_idx] <= {req_bytes_reg, req_stamp_reg};
        end
        mem_rdata <= data_mem[mem_raddr];
    end

    always_comb begin
        state_next       = state_reg;
        key_next         = key_reg;
        age_next         = age_reg;
        valid_next       = valid_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        max_bytes_next   = max_bytes_reg;
        max_entries_next = max_entries_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        slot_next        = slot_reg;
        victim_next      = victim_reg;
        ins_pend_next    = ins_pend_reg;
        evicted_next     = evicted_reg;
        status_next      = status_reg;
        stays_next       = stays_reg;
        out_valid_next   = out_valid_reg;

        if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_MAX_BYTES) begin
                max_bytes_next = cfg_data;
            end else if (cfg_index == REG_MAX_ENTRIES) begin
                max_entries_next = cfg_data[LIM_W-1:0];
            end
        end

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    evicted_next  = '0;
                    ins_pend_next = 1'b0;
                    stays_next    = 1'b0;
                    state_next    = S_LOOK;
                end
            end
            S_LOOK: begin
                hit_next     = srch.hit;
                hit_idx_next = srch.hit_idx;
                state_next   = S_CHECK;
            end
            S_CHECK: begin
                if (hit_ok) begin
                    for (int j = 0; j < ENTRIES; j++) begin
                        if (valid_reg[j] && age_reg[j] < age_reg[hit_idx_reg]) begin
                            age_next[j] = age_t'(age_reg[j] + age_t'(1));
                        end
                    end
                    age_next[hit_idx_reg] = '0;
                    status_next = ST_HIT;
                    stays_next  = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    if (hit_reg) begin
                        // Stale entry: close its rank gap and take back its bytes.
                        valid_next[hit_idx_reg] = 1'b0;
                        for (int j = 0; j < ENTRIES; j++) begin
                            if (valid_reg[j] && age_reg[j] > age_reg[hit_idx_reg]) begin
                                age_next[j] = age_t'(age_reg[j] - age_t'(1));
                            end
                        end
                        total_next = sub_sat(total_reg, rd_bytes);
                        count_next = cnt_t'(count_reg - cnt_t'(1));
                    end
                    if (!req_readable_reg) begin
                        status_next = ST_UNREAD;
                        state_next  = S_DONE;
                    end else begin
                        status_next = hit_reg ? ST_STALE : ST_LOADED;
                        state_next  = S_INS;
                    end
                end
            end
            S_INS: begin
                if (count_reg == cnt_t'(ENTRIES)) begin
                    // Full table: make room by evicting the oldest entry first.
                    ins_pend_next = 1'b1;
                    state_next    = S_EVRD;
                end else begin
                    for (int j = 0; j < ENTRIES; j++) begin
                        if (valid_reg[j]) begin
                            age_next[j] = age_t'(age_reg[j] + age_t'(1));
                        end
                    end
                    age_next[srch.free_idx]   = '0;
                    valid_next[srch.free_idx] = 1'b1;
                    key_next[srch.free_idx]   = req_key_reg;
                    total_next    = total_t'(total_reg + total_t'(req_bytes_reg));
                    count_next    = cnt_t'(count_reg + cnt_t'(1));
                    slot_next     = srch.free_idx;
                    ins_pend_next = 1'b0;
                    state_next    = S_TRIM;
                end
            end
            S_EVRD: begin
                victim_next = srch.old_idx;
                state_next  = S_EVICT;
            end
            S_EVICT: begin
                // The oldest entry holds the top rank, so no other rank moves.
                valid_next[victim_reg] = 1'b0;
                total_next   = sub_sat(total_reg, rd_bytes);
                count_next   = cnt_t'(count_reg - cnt_t'(1));
                evicted_next = cnt_t'(evicted_reg + cnt_t'(1));
                state_next   = ins_pend_reg ? S_INS : S_TRIM;
            end
            S_TRIM: begin
                if (count_reg != '0 && (total_reg > max_bytes_reg || count_reg > limit)) begin
                    state_next = S_EVRD;
                end else begin
                    stays_next = valid_reg[slot_reg];
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            age_reg         <= '0;
            count_reg       <= '0;
            total_reg       <= '0;
            max_bytes_reg   <= total_t'(64'd16777216);
            max_entries_reg <= LIM_W'(ENTRIES);
            out_valid_reg   <= 1'b0;
            hit_reg         <= 1'b0;
            ins_pend_reg    <= 1'b0;
            evicted_reg     <= '0;
        end else begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            age_reg         <= age_next;
            count_reg       <= count_next;
            total_reg       <= total_next;
            max_bytes_reg   <= max_bytes_next;
            max_entries_reg <= max_entries_next;
            out_valid_reg   <= out_valid_next;
            hit_reg         <= hit_next;
            ins_pend_reg    <= ins_pend_next;
            evicted_reg     <= evicted_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        hit_idx_reg <= hit_idx_next;
        slot_reg    <= slot_next;
        victim_reg  <= victim_next;
        status_reg  <= status_next;
        stays_reg   <= stays_next;
        if (accept) begin
            req_key_reg      <= s_key;
            req_bytes_reg    <= s_item_bytes;
            req_stamp_reg    <= s_stamp;
            req_readable_reg <= s_readable;
        end
        if (out_load) begin
            out_status_reg  <= status_reg;
            out_stays_reg   <= stays_reg;
            out_evicted_reg <= evicted_reg;
            out_total_reg   <= total_reg;
            out_count_reg   <= count_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_stays_cached  = out_stays_reg;
    assign m_evicted_count = 5'(out_evicted_reg);
    assign m_total_bytes   = out_total_reg;
    assign m_entry_count   = 5'(out_count_reg);

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression bench for the size-budget LRU cache directory. Requests are
// driven with random gaps, results are drained with random stalls, and each
// result word is compared with a software copy of the directory.
// ----------------------------------------------------------------------------
module tb;
    import sblc_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SIZE_W-1:0]  nbytes;
        logic [STAMP_W-1:0] stamp;
        logic               readable;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               stays;
        logic [4:0]         evicted;
        logic [TOTAL_W-1:0] total;
        logic [4:0]         count;
    } res_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0, s_ready;
    logic [KEY_W-1:0] s_key = '0;
    logic [SIZE_W-1:0] s_item_bytes = '0;
    logic [STAMP_W-1:0] s_stamp = '0;
    logic s_readable = 0;
    logic m_valid, m_ready = 0;
    logic [1:0] m_status;
    logic m_stays_cached;
    logic [4:0] m_evicted_count;
    logic [TOTAL_W-1:0] m_total_bytes;
    logic [4:0] m_entry_count;
    logic cfg_valid = 0, cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [TOTAL_W-1:0] cfg_data = '0;

    size_budget_lru_cache dut (.*);

    initial forever #10 aclk = ~aclk;

    // Directory copy used for prediction.
    logic [KEY_W-1:0]   dir_key   [ENTRIES];
    logic [SIZE_W-1:0]  dir_bytes [ENTRIES];
    logic [STAMP_W-1:0] dir_stamp [ENTRIES];
    bit                 dir_valid [ENTRIES];
    int unsigned        dir_age   [ENTRIES];
    logic [63:0]        dir_total;
    logic [TOTAL_W-1:0] budget_bytes = 36'd16777216;
    logic [4:0]         budget_entries = 5'd16;

    req_t request_q[$];
    res_t result_q[$];
    int   errors = 0;
    int   results_seen = 0;
    int   hits_seen = 0, evictions_seen = 0;
    bit   idle_on = 1;
    bit   hold_off = 0;
    int   stall_left = 0;
    int   quiet_cycles = 0;

    function automatic int live_entries();
        int n = 0;
        for (int i = 0; i < ENTRIES; i++) if (dir_valid[i]) n++;
        return n;
    endfunction

    function automatic void drop_slot(int i);
        dir_valid[i] = 0;
        for (int j = 0; j < ENTRIES; j++)
            if (dir_valid[j] && dir_age[j] > dir_age[i]) dir_age[j]--;
        dir_total -= (dir_total >= dir_bytes[i]) ? dir_bytes[i] : dir_total;
    endfunction

    function automatic int lru_slot();
        int best = ENTRIES;
        for (int i = 0; i < ENTRIES; i++)
            if (dir_valid[i] && (best == ENTRIES || dir_age[i] > dir_age[best])) best = i;
        return best;
    endfunction

    function automatic res_t lookup_and_update(req_t r);
        res_t o;
        int hit = ENTRIES, slot = ENTRIES, v, lim, ev = 0;
        o = '0;
        lim = (budget_entries < ENTRIES) ? budget_entries : ENTRIES;
        for (int i = 0; i < ENTRIES; i++)
            if (hit == ENTRIES && dir_valid[i] && dir_key[i] == r.key) hit = i;
        if (hit < ENTRIES && r.readable && dir_bytes[hit] == r.nbytes &&
            dir_stamp[hit] == r.stamp) begin
            for (int j = 0; j < ENTRIES; j++)
                if (dir_valid[j] && dir_age[j] < dir_age[hit]) dir_age[j]++;
            dir_age[hit] = 0;
            o.status = ST_HIT;
            o.stays = 1;
        end else begin
            if (hit < ENTRIES) drop_slot(hit);
            if (!r.readable) begin
                o.status = ST_UNREAD;
            end else begin
                o.status = (hit < ENTRIES) ? ST_STALE : ST_LOADED;
                if (live_entries() >= ENTRIES) begin
                    v = lru_slot();
                    if (v < ENTRIES) begin
                        drop_slot(v);
                        ev++;
                    end
                end
                for (int i = 0; i < ENTRIES; i++)
                    if (slot == ENTRIES && !dir_valid[i]) slot = i;
                if (slot < ENTRIES) begin
                    for (int j = 0; j < ENTRIES; j++) if (dir_valid[j]) dir_age[j]++;
                    dir_key[slot] = r.key;
                    dir_bytes[slot] = r.nbytes;
                    dir_stamp[slot] = r.stamp;
                    dir_age[slot] = 0;
                    dir_valid[slot] = 1;
                    dir_total += r.nbytes;
                    while (dir_total > budget_bytes || live_entries() > lim) begin
                        v = lru_slot();
                        if (v >= ENTRIES) break;
                        drop_slot(v);
                        ev++;
                    end
                    o.stays = dir_valid[slot];
                end
            end
        end
        o.evicted = (ev > 31) ? 5'd31 : 5'(ev);
        o.total = (dir_total > 64'hF_FFFF_FFFF) ? '1 : dir_total[TOTAL_W-1:0];
        o.count = 5'(live_entries());
        return o;
    endfunction

    // Request driver.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                result_q.push_back(lookup_and_update({s_key, s_item_bytes, s_stamp,
                                                      s_readable}));
            end
            if ((!s_valid || s_ready) && request_q.size() > 0 &&
                !(idle_on && $urandom_range(99) < 23)) begin
                s_valid <= 1;
                {s_key, s_item_bytes, s_stamp, s_readable} <= request_q.pop_front();
            end else if (s_valid && s_ready) begin
                s_valid <= 0;
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_status, m_stays_cached, m_evicted_count, m_total_bytes,
                       m_entry_count};
                results_seen++;
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, got);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (want.status == ST_HIT) hits_seen++;
                    evictions_seen += want.evicted;
                    if (got.status !== want.status) begin
                        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                        errors++;
                    end
                    if (got.stays !== want.stays) begin
                        $display("%0t: stays_cached exp %0d got %0d", $time, want.stays,
                                 got.stays);
                        errors++;
                    end
                    if (got.evicted !== want.evicted) begin
                        $display("%0t: evicted_count exp %0d got %0d", $time, want.evicted,
                                 got.evicted);
                        errors++;
                    end
                    if (got.total !== want.total) begin
                        $display("%0t: total_bytes exp %0d got %0d", $time, want.total,
                                 got.total);
                        errors++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: entry_count exp %0d got %0d", $time, want.count,
                                 got.count);
                        errors++;
                    end
                end
            end
            if (hold_off) begin
                stall_left <= 300;
                m_ready <= 0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 0;
            end else begin
                m_ready <= !(idle_on && $urandom_range(99) < 23);
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("size_budget_lru_cache regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [TOTAL_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        if (idx == REG_MAX_BYTES) budget_bytes = val;
        else if (idx == REG_MAX_ENTRIES) budget_entries = val[4:0];
    endtask

    task automatic drain();
        while (request_q.size() > 0 || s_valid || result_q.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic req_t make_req(input logic [KEY_W-1:0] k, input logic [SIZE_W-1:0] b,
                                      input logic [STAMP_W-1:0] st, input bit rd);
        req_t r;
        r.key = k;
        r.nbytes = b;
        r.stamp = st;
        r.readable = rd;
        return r;
    endfunction

    // Mostly reuses a small key pool so hits and stale reloads are common.
    task automatic queue_random(input int n, input int size_max);
        req_t r;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 8) begin
                r.key = $urandom_range(23);
                if ($urandom_range(3) == 0) r.nbytes = r.key * 7;
                else r.nbytes = r.key * 7 + $urandom_range(1);
                r.stamp = 64'((r.key << 2) | $urandom_range(1));
                r.readable = ($urandom_range(9) != 0);
            end else begin
                r.key = $urandom();
                r.nbytes = $urandom();
                r.stamp = {$urandom(), $urandom()};
                r.readable = 1'($urandom_range(1));
            end
            if (size_max > 1000 && $urandom_range(3) == 0) r.nbytes = $urandom_range(size_max);
            request_q.push_back(r);
        end
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            dir_valid[i] = 0;
            dir_age[i] = 0;
        end
        dir_total = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        // Directed: extremes, hit, stale size, stale stamp, unreadable, full table.
        request_q.push_back(make_req('0, '0, '0, 1'b1));
        request_q.push_back(make_req('0, '0, '0, 1'b1));
        request_q.push_back(make_req('1, '1, '1, 1'b1));
        request_q.push_back(make_req('1, '1, '1, 1'b1));
        request_q.push_back(make_req('1, 32'd5, '1, 1'b1));
        request_q.push_back(make_req('1, 32'd5, 64'h8000_0000_0000_0000, 1'b1));
        request_q.push_back(make_req('1, 32'd5, 64'h8000_0000_0000_0000, 1'b0));
        request_q.push_back(make_req(32'h1234, 32'd9, 64'd3, 1'b0));
        for (int i = 0; i < 17; i++)
            request_q.push_back(make_req(32'h100 + i, 32'd100, 64'(i), 1'b1));
        drain();

        write_reg(REG_MAX_ENTRIES, 36'd0);
        request_q.push_back(make_req(32'h55, 32'd1, 64'd1, 1'b1));
        drain();
        write_reg(REG_MAX_ENTRIES, 36'd31);
        write_reg(REG_MAX_BYTES, 36'd0);
        request_q.push_back(make_req(32'h56, 32'd1, 64'd1, 1'b1));
        request_q.push_back(make_req(32'h57, 32'd0, 64'd1, 1'b1));
        drain();
        write_reg(REG_MAX_BYTES, '1);
        write_reg(REG_MAX_ENTRIES, 36'd16);

        // Random phases at several settings; the next to last one runs without idling.
        queue_random(400, 32'hFFFF_FFFF);
        drain();
        write_reg(REG_MAX_BYTES, 36'd120);
        write_reg(REG_MAX_ENTRIES, 36'd5);
        queue_random(400, 40);
        // Hold the result side off while requests keep coming.
        repeat (20) @(posedge aclk);
        hold_off <= 1;
        @(posedge aclk);
        hold_off <= 0;
        drain();
        write_reg(REG_MAX_BYTES, 36'd500);
        write_reg(REG_MAX_ENTRIES, 36'd12);
        queue_random(400, 80);
        drain();
        write_reg(REG_MAX_BYTES, 36'd16777216);
        write_reg(REG_MAX_ENTRIES, 36'd1);
        idle_on = 0;
        queue_random(200, 1000);
        drain();
        write_reg(REG_MAX_ENTRIES, 36'd16);
        idle_on = 1;
        queue_random(300, 200);
        drain();

        if (result_q.size() != 0) errors++;
        $display("Checked %0d results: %0d hits, %0d evictions, over seven limit settings.",
                 results_seen, hits_seen, evictions_seen);
        if (errors == 0)
            $display("size_budget_lru_cache regression: pass");
        else
            $display("size_budget_lru_cache regression: fail");
        $finish;
    end
endmodule
